// ===== hdl/ilid_pkg.sv =====
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants of the indexed list
// Command and response layouts, command kinds, status codes and the
// per-cell control bundle.
// ----------------------------------------------------------------------------
package ilid_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = 8;
	localparam int LEN_W = 7;
	localparam int DATA_W = 32;
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [2:0] KIND_READ = 3'd0;
	localparam logic [2:0] KIND_HEAD = 3'd1;
	localparam logic [2:0] KIND_TAIL = 3'd2;
	localparam logic [2:0] KIND_AT = 3'd3;
	localparam logic [2:0] KIND_DEL = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [IDX_W-1:0] index;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic found;
		logic [1:0] status;
		logic [LEN_W-1:0] length;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic [CNT_W-1:0] pos;
	} ctl_t;

endpackage

// ===== hdl/ilid_cell.sv =====
// ----------------------------------------------------------------------------
// ilid_cell: one storage cell of the list
// Holds one entry; on insert it loads the new value or its left neighbor,
// on delete it loads its right neighbor, and it drives its entry onto the
// read bus when its position matches.
// ----------------------------------------------------------------------------
module ilid_cell (
	input  logic clk,
	input  logic [ilid_pkg::CNT_W-1:0] id,
	input  ilid_pkg::ctl_t ctl,
	input  logic [ilid_pkg::DATA_W-1:0] value,
	input  logic [ilid_pkg::DATA_W-1:0] left,
	input  logic [ilid_pkg::DATA_W-1:0] right,
	output logic [ilid_pkg::DATA_W-1:0] data,
	output logic [ilid_pkg::DATA_W-1:0] tap
);
	import ilid_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic at_pos;
	logic past_pos;

	assign at_pos = (id == ctl.pos);
	assign past_pos = (id > ctl.pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				data_q <= value;
			end else if (past_pos) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (at_pos || past_pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign tap = at_pos ? data_q : '0;

endmodule

// ===== hdl/ilid_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilid_ctrl: command decode and entry count
// Checks each command against the count, produces the cell controls and
// the response fields other than the read data, and keeps the count.
// ----------------------------------------------------------------------------
module ilid_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  ilid_pkg::cmd_t cmd,
	output ilid_pkg::ctl_t ctl,
	output ilid_pkg::rsp_t res
);
	import ilid_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic full;
	logic ins;
	logic del;
	logic found;
	logic [1:0] status;
	logic [CNT_W-1:0] pos;

	assign idx_ext = CMP_W'(cmd.index);
	assign cnt_ext = CMP_W'(count_q);
	assign full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		ins = 1'b0;
		del = 1'b0;
		found = 1'b0;
		status = ST_DONE;
		pos = idx_ext[CNT_W-1:0];
		case (cmd.kind)
			KIND_READ: begin
				if (idx_ext < cnt_ext) begin
					found = 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			KIND_HEAD: begin
				pos = '0;
				if (full) begin
					status = ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			KIND_TAIL: begin
				pos = count_q;
				if (full) begin
					status = ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			KIND_AT: begin
				if (idx_ext > cnt_ext) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			KIND_DEL: begin
				if (idx_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					del = 1'b1;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (del) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	assign ctl.ins = accept && ins;
	assign ctl.del = accept && del;
	assign ctl.pos = pos;

	assign res.read_value = '1;
	assign res.found = found;
	assign res.status = status;
	assign res.length = LEN_W'(count_nxt);

endmodule

// ===== hdl/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list with indexed insert and delete
// Commands arrive on the cmd channel (valid/ready) and each gives one
// response on the rsp channel (valid/ready). A command reads, inserts at
// the head, appends, inserts before an index or deletes at an index.
// The list lives in a row of cells; every cell compares its own position
// with the command position, so the whole shift completes at the accepting
// edge. The response is registered at that edge and rsp_valid rises with
// it. Throughput is one transaction per cycle while the receiver takes each
// response, set by the cell update and the one output register.
// When the receiver stalls, the response is held in the output register
// and cmd_ready drops until it is taken.
// Reset clears the entry count and the response valid flag; the entries
// themselves are not cleared, since positions past the count are never
// read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  ilid_pkg::cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output ilid_pkg::rsp_t rsp
);
	import ilid_pkg::*;

	logic accept;
	ctl_t ctl;
	rsp_t res;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [DATA_W-1:0] data [CAPACITY];
	logic [DATA_W-1:0] tap [CAPACITY];
	logic [DATA_W-1:0] bus;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept = cmd_valid && cmd_ready;

	ilid_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.ctl(ctl),
		.res(res)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = cmd.value;
		end else begin : g_mid
			assign left = data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = data[i];
		end else begin : g_inner
			assign right = data[i+1];
		end

		ilid_cell u_cell (
			.clk(clk),
			.id(CNT_W'(i)),
			.ctl(ctl),
			.value(cmd.value),
			.left(left),
			.right(right),
			.data(data[i]),
			.tap(tap[i])
		);
	end

	always_comb begin
		bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			bus = bus | tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value <= res.found ? bus : res.read_value;
			rsp_q.found <= res.found;
			rsp_q.status <= res.status;
			rsp_q.length <= res.length;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
